### sv/ordered_list_table_unit_macros.svh
// Assertion macros for the ordered list table unit.
// Used by the port checker; no other dependencies.
`ifndef ORDERED_LIST_TABLE_UNIT_MACROS_SVH
`define ORDERED_LIST_TABLE_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define OLT_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ordered list table check failed");

// Next-cycle implication, disabled during reset.
`define OLT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ordered list table check failed");

`endif

### sv/olt_pkg.sv
// Shared types and constants for the ordered list table unit.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package olt_pkg;

   localparam int KEY_W     = 32;
   localparam int PAYLOAD_W = 32;
   localparam int OP_W      = 3;
   localparam int POS_W     = 5;
   localparam int STATUS_W  = 3;
   localparam int COUNT_W   = 5;

   typedef enum logic [OP_W-1:0] {
      OP_INS_FRONT = 3'd0,
      OP_INS_BACK  = 3'd1,
      OP_INS_AT    = 3'd2,
      OP_REM_FRONT = 3'd3,
      OP_REM_BACK  = 3'd4,
      OP_REM_AT    = 3'd5,
      OP_LOOKUP    = 3'd6
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK     = 3'd0,
      ST_FULL   = 3'd1,
      ST_EMPTY  = 3'd2,
      ST_BADPOS = 3'd3,
      ST_NOKEY  = 3'd4
   } status_type;

   typedef enum logic {
      S_IDLE   = 1'b0,
      S_SEARCH = 1'b1
   } state_type;

   // Shift command broadcast to every cell
   typedef struct packed {
      logic shift_up;
      logic shift_down;
   } shift_cmd_type;

   // Search token walking down the cell chain
   typedef struct packed {
      logic                 valid;
      logic                 hit;
      logic [PAYLOAD_W-1:0] payload;
   } token_type;

endpackage

`default_nettype wire

### sv/ordered_list_table_unit.sv
// Ordered list table unit: top level, command decode, entry count, result
// register and the chain of olt_cell entries. Depends on olt_pkg, olt_cell.
//
// Holds an ordered list of up to DEPTH entries (key + payload) in a row of
// cells. Each request transaction is one operation: insert front/back/at,
// remove front/back/at, or lookup. Inserts and removes shift every cell at
// once, so their response is registered the cycle after the request is
// taken. A lookup sends a search token down the cell chain, one cell per
// cycle; its response is registered when the token leaves the last cell.
// One operation is in flight at a time; the next request is taken as soon
// as the previous response has been taken or is being taken. Full, empty
// and out-of-range positions are flagged in rsp_status and leave the table
// unchanged. rsp_entry_count is the count after the operation, low 5 bits.
// No clearing pass after reset.
`timescale 1ns / 1ps
`default_nettype none

module ordered_list_table_unit #(
   parameter int DEPTH = 16
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_ready,
   input  wire logic [olt_pkg::OP_W-1:0]              req_operation,
   input  wire logic [olt_pkg::POS_W-1:0]             req_position,
   input  wire logic signed [olt_pkg::KEY_W-1:0]      req_key,
   input  wire logic [olt_pkg::PAYLOAD_W-1:0]         req_payload,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_ready,
   output logic [olt_pkg::STATUS_W-1:0]               rsp_status,
   output logic [olt_pkg::PAYLOAD_W-1:0]              rsp_found_payload,
   output logic [olt_pkg::COUNT_W-1:0]                rsp_entry_count
);
   import olt_pkg::*;

   // count needs to hold DEPTH itself
   localparam int CW   = $clog2(DEPTH + 1);
   // compare width wide enough for both count and the position field
   localparam int CMPW = (CW > POS_W) ? CW : POS_W;
   localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

   // --- control state ---
   state_type               state_ff, state_in;
   logic [CW-1:0]           count_ff, count_in;
   logic                    start_ff, start_in;
   logic signed [KEY_W-1:0] search_key_ff, search_key_in;

   // --- response register ---
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]     rsp_status_ff, rsp_status_in;
   logic [PAYLOAD_W-1:0]    rsp_found_ff, rsp_found_in;
   logic [COUNT_W-1:0]      rsp_count_ff, rsp_count_in;

   // --- decode ---
   logic                    req_fire;
   logic                    full;
   logic                    empty;
   logic [CMPW-1:0]         pos_ext;
   logic [CMPW-1:0]         cnt_ext;
   logic [CMPW-1:0]         pos_minus1;
   status_type              dec_status;
   shift_cmd_type           dec_cmd;
   shift_cmd_type           cell_cmd;
   logic [CW-1:0]           dec_at;
   logic                    dec_lookup;
   logic                    search_done;

   // --- cell chain ---
   logic signed [KEY_W-1:0] cell_key     [DEPTH];
   logic [PAYLOAD_W-1:0]    cell_payload [DEPTH];
   token_type               cell_tok     [DEPTH];
   token_type               start_tok;

   assign req_fire   = req_valid && req_ready;
   assign full       = (count_ff == FULL_COUNT);
   assign empty      = (count_ff == '0);
   assign pos_ext    = CMPW'(req_position);
   assign cnt_ext    = CMPW'(count_ff);
   assign pos_minus1 = pos_ext - CMPW'(1);

   // Operation decode against the current count. Error cases leave the
   // shift command clear so the table stays untouched.
   always_comb begin
      dec_status = ST_OK;
      dec_cmd    = '0;
      dec_at     = '0;
      dec_lookup = 1'b0;
      case (op_type'(req_operation))
         OP_INS_FRONT: begin
            if (full) begin
               dec_status = ST_FULL;
            end else begin
               dec_cmd.shift_up = 1'b1;
            end
         end
         OP_INS_BACK: begin
            if (full) begin
               dec_status = ST_FULL;
            end else begin
               dec_cmd.shift_up = 1'b1;
               dec_at           = count_ff;
            end
         end
         OP_INS_AT: begin
            if (full) begin
               dec_status = ST_FULL;
            end else if (pos_ext > cnt_ext) begin
               dec_status = ST_BADPOS;
            end else begin
               dec_cmd.shift_up = 1'b1;
               dec_at           = pos_ext[CW-1:0];
            end
         end
         OP_REM_FRONT: begin
            if (empty) begin
               dec_status = ST_EMPTY;
            end else begin
               dec_cmd.shift_down = 1'b1;
            end
         end
         OP_REM_BACK: begin
            if (empty) begin
               dec_status = ST_EMPTY;
            end else begin
               dec_cmd.shift_down = 1'b1;
               dec_at             = count_ff - CW'(1);
            end
         end
         OP_REM_AT: begin
            if (empty) begin
               dec_status = ST_EMPTY;
            end else if ((pos_ext == '0) || (pos_ext > cnt_ext)) begin
               dec_status = ST_BADPOS;
            end else begin
               dec_cmd.shift_down = 1'b1;
               dec_at             = pos_minus1[CW-1:0];
            end
         end
         OP_LOOKUP: begin
            if (empty) begin
               dec_status = ST_EMPTY;
            end else begin
               dec_lookup = 1'b1;
            end
         end
         default: begin
            // unused code: no change, status ok
         end
      endcase
   end

   assign cell_cmd = req_fire ? dec_cmd : '0;

   // search completes when the token leaves the last cell
   assign search_done = (state_ff == S_SEARCH) && cell_tok[DEPTH-1].valid;

   // FSM, count and response register next state
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      start_in      = 1'b0;
      search_key_in = search_key_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_count_in  = rsp_count_ff;
      req_ready     = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = !rsp_valid_ff || rsp_ready;
            if (req_valid && req_ready) begin
               if (dec_lookup) begin
                  state_in      = S_SEARCH;
                  start_in      = 1'b1;
                  search_key_in = req_key;
               end else begin
                  if (dec_cmd.shift_up) begin
                     count_in = count_ff + CW'(1);
                  end else if (dec_cmd.shift_down) begin
                     count_in = count_ff - CW'(1);
                  end
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = dec_status;
                  rsp_found_in  = '0;
                  rsp_count_in  = COUNT_W'(count_in);
               end
            end
         end
         S_SEARCH: begin
            if (search_done) begin
               state_in      = S_IDLE;
               rsp_valid_in  = 1'b1;
               rsp_status_in = cell_tok[DEPTH-1].hit ? ST_OK : ST_NOKEY;
               rsp_found_in  = cell_tok[DEPTH-1].hit ? cell_tok[DEPTH-1].payload : '0;
               rsp_count_in  = COUNT_W'(count_ff);
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         start_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         start_ff     <= start_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      search_key_ff <= search_key_in;
      rsp_status_ff <= rsp_status_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_count_ff  <= rsp_count_in;
   end

   // token injected into cell 0 the cycle after the lookup is taken
   assign start_tok = '{valid: start_ff, hit: 1'b0, payload: '0};

   // Cell chain: cell g reads its left (g-1) and right (g+1) neighbors.
   // The first cell has no left neighbor and the last none on the right;
   // those inputs only feed slots that are beyond the count.
   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      logic signed [KEY_W-1:0] lkey, rkey;
      logic [PAYLOAD_W-1:0]    lpay, rpay;
      token_type               tprev;

      if (g == 0) begin : g_first
         assign lkey  = '0;
         assign lpay  = '0;
         assign tprev = start_tok;
      end else begin : g_mid
         assign lkey  = cell_key[g-1];
         assign lpay  = cell_payload[g-1];
         assign tprev = cell_tok[g-1];
      end

      if (g == DEPTH - 1) begin : g_last
         assign rkey = '0;
         assign rpay = '0;
      end else begin : g_inner
         assign rkey = cell_key[g+1];
         assign rpay = cell_payload[g+1];
      end

      olt_cell #(
         .INDEX (g),
         .CW    (CW)
      ) u_cell (
         .clock         (clock),
         .reset         (reset),
         .cmd           (cell_cmd),
         .at            (dec_at),
         .new_key       (req_key),
         .new_payload   (req_payload),
         .left_key      (lkey),
         .left_payload  (lpay),
         .right_key     (rkey),
         .right_payload (rpay),
         .count         (count_ff),
         .search_key    (search_key_ff),
         .tok_prev      (tprev),
         .key           (cell_key[g]),
         .payload       (cell_payload[g]),
         .tok           (cell_tok[g])
      );
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_found_payload = rsp_found_ff;
   assign rsp_entry_count   = rsp_count_ff;

endmodule

`default_nettype wire

### sv/olt_cell.sv
// One entry cell of the ordered list table: key/payload storage, shift
// muxing and one stage of the lookup token chain. Depends on olt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module olt_cell #(
   parameter int INDEX = 0,
   parameter int CW    = 5
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire olt_pkg::shift_cmd_type               cmd,
   input  wire logic [CW-1:0]                        at,
   input  wire logic signed [olt_pkg::KEY_W-1:0]     new_key,
   input  wire logic [olt_pkg::PAYLOAD_W-1:0]        new_payload,
   input  wire logic signed [olt_pkg::KEY_W-1:0]     left_key,
   input  wire logic [olt_pkg::PAYLOAD_W-1:0]        left_payload,
   input  wire logic signed [olt_pkg::KEY_W-1:0]     right_key,
   input  wire logic [olt_pkg::PAYLOAD_W-1:0]        right_payload,
   input  wire logic [CW-1:0]                        count,
   input  wire logic signed [olt_pkg::KEY_W-1:0]     search_key,
   input  wire olt_pkg::token_type                   tok_prev,
   output logic signed [olt_pkg::KEY_W-1:0]          key,
   output logic [olt_pkg::PAYLOAD_W-1:0]             payload,
   output olt_pkg::token_type                        tok
);
   import olt_pkg::*;

   localparam logic [CW-1:0] MY_IDX = CW'(INDEX);

   logic signed [KEY_W-1:0] key_ff, key_in;
   logic [PAYLOAD_W-1:0]    payload_ff, payload_in;
   token_type               tok_ff, tok_in;

   always_comb begin
      key_in     = key_ff;
      payload_in = payload_ff;
      if (cmd.shift_up) begin
         if (MY_IDX == at) begin
            key_in     = new_key;
            payload_in = new_payload;
         end else if (MY_IDX > at) begin
            key_in     = left_key;
            payload_in = left_payload;
         end
      end else if (cmd.shift_down) begin
         if (MY_IDX >= at) begin
            key_in     = right_key;
            payload_in = right_payload;
         end
      end
   end

   // later match overrides earlier one: last matching entry wins
   always_comb begin
      tok_in = tok_prev;
      if (tok_prev.valid && (count > MY_IDX) && (key_ff == search_key)) begin
         tok_in.hit     = 1'b1;
         tok_in.payload = payload_ff;
      end
   end

   always_ff @(posedge clock) begin
      key_ff     <= key_in;
      payload_ff <= payload_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff <= '0;
      end else begin
         tok_ff <= tok_in;
      end
   end

   assign key     = key_ff;
   assign payload = payload_ff;
   assign tok     = tok_ff;

endmodule

`default_nettype wire

### sv/olt_checker.sv
// Port-level checks for the ordered list table unit, bound to the top level.
// Depends on olt_pkg and ordered_list_table_unit_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "ordered_list_table_unit_macros.svh"

module olt_checker #(
   parameter int DEPTH = 16
) (
   input wire logic                                  clock,
   input wire logic                                  reset,
   input wire logic                                  req_valid,
   input wire logic                                  req_ready,
   input wire logic [olt_pkg::OP_W-1:0]              req_operation,
   input wire logic [olt_pkg::POS_W-1:0]             req_position,
   input wire logic signed [olt_pkg::KEY_W-1:0]      req_key,
   input wire logic [olt_pkg::PAYLOAD_W-1:0]         req_payload,
   input wire logic                                  rsp_valid,
   input wire logic                                  rsp_ready,
   input wire logic [olt_pkg::STATUS_W-1:0]          rsp_status,
   input wire logic [olt_pkg::PAYLOAD_W-1:0]         rsp_found_payload,
   input wire logic [olt_pkg::COUNT_W-1:0]           rsp_entry_count
);
   import olt_pkg::*;

   localparam logic [COUNT_W-1:0] FULL_CNT = COUNT_W'(DEPTH);

   // waiting request transaction stays put until taken
   `OLT_ASSERT_NEXT(a_req_hold, clock, reset, req_valid && !req_ready,
      req_valid && $stable(req_operation) && $stable(req_position)
      && $stable(req_key) && $stable(req_payload))

   // held response stays put until taken
   `OLT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_status) && $stable(rsp_found_payload)
      && $stable(rsp_entry_count))

   // only a successful lookup carries a payload
   `OLT_ASSERT_IMPL(a_found_zero, clock, reset, rsp_valid && (rsp_status != ST_OK),
      rsp_found_payload == '0)

   // full status only with the table at capacity
   `OLT_ASSERT_IMPL(a_full_count, clock, reset, rsp_valid && (rsp_status == ST_FULL),
      rsp_entry_count == FULL_CNT)

   // empty status only with nothing held
   `OLT_ASSERT_IMPL(a_empty_count, clock, reset, rsp_valid && (rsp_status == ST_EMPTY),
      rsp_entry_count == '0)

endmodule

bind ordered_list_table_unit olt_checker #(.DEPTH(DEPTH)) u_olt_checker (.*);

`default_nettype wire

### test/tb_ordered_list_table_unit.sv
// Testbench for ordered_list_table_unit: random and directed list operations,
// checked against an in-bench list predictor. Depends on olt_pkg and the DUT.
`timescale 1ns / 1ps

module tb_ordered_list_table_unit;
   import olt_pkg::*;

   localparam int LIST_DEPTH = 16;
   localparam int RANDOM_OPS = 550;
   localparam int CALM_TAIL  = 60;      // last ops draw no random idle bursts
   localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;

   // One request transaction plus the pacing flags the driver honors.
   typedef struct {
      logic [OP_W-1:0]         operation;
      logic [POS_W-1:0]        position;
      logic signed [KEY_W-1:0] key;
      logic [PAYLOAD_W-1:0]    payload;
      bit                      wait_drained;  // hold until nothing outstanding
      bit                      calm;          // no idling around this one
   } list_op_type;

   typedef struct {
      status_type           status;
      logic [PAYLOAD_W-1:0] found_payload;
      logic [COUNT_W-1:0]   entry_count;
   } list_rsp_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_ready;
   logic [OP_W-1:0]         req_operation = '0;
   logic [POS_W-1:0]        req_position = '0;
   logic signed [KEY_W-1:0] req_key = '0;
   logic [PAYLOAD_W-1:0]    req_payload = '0;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   logic [STATUS_W-1:0]     rsp_status;
   logic [PAYLOAD_W-1:0]    rsp_found_payload;
   logic [COUNT_W-1:0]      rsp_entry_count;

   ordered_list_table_unit #(
      .DEPTH(LIST_DEPTH)
   ) i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_operation    (req_operation),
      .req_position     (req_position),
      .req_key          (req_key),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_found_payload(rsp_found_payload),
      .rsp_entry_count  (rsp_entry_count)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Pending stimulus, predicted responses, and the predictor's copy of the list
   list_op_type             queued_ops[$];
   list_rsp_type            predicted_rsps[$];
   logic signed [KEY_W-1:0] list_keys[LIST_DEPTH];
   logic [PAYLOAD_W-1:0]    list_payloads[LIST_DEPTH];
   int                      list_count = 0;

   // Handshake totals; nonblocking so every reader sees pre-edge values
   int                      ops_sent = 0;
   int                      rsps_seen = 0;
   int                      error_count = 0;
   bit                      calm_phase = 1'b0;

   // Stimulus side bookkeeping: rough count tracker to keep positions sensible
   int                      gen_count = 0;
   bit                      gen_hold = 1'b0;
   bit                      gen_calm = 1'b0;
   logic signed [KEY_W-1:0] key_pool[8];

   // Applies one operation to the predicted list and returns its response.
   function automatic list_rsp_type apply_list_op(input list_op_type op);
      list_rsp_type rsp;
      int           slot;
      int           pos;
      rsp.status        = ST_OK;
      rsp.found_payload = '0;
      pos               = int'(op.position);
      case (op.operation)
         OP_INS_FRONT, OP_INS_BACK, OP_INS_AT: begin
            slot = (op.operation == OP_INS_FRONT) ? 0 :
                   (op.operation == OP_INS_BACK)  ? list_count : pos;
            if (list_count >= LIST_DEPTH) begin
               rsp.status = ST_FULL;
            end else if (slot > list_count) begin
               rsp.status = ST_BADPOS;
            end else begin
               for (int i = list_count; i > slot; i--) begin
                  list_keys[i]     = list_keys[i-1];
                  list_payloads[i] = list_payloads[i-1];
               end
               list_keys[slot]     = op.key;
               list_payloads[slot] = op.payload;
               list_count++;
            end
         end
         OP_REM_FRONT, OP_REM_BACK, OP_REM_AT: begin
            slot = (op.operation == OP_REM_FRONT) ? 0 :
                   (op.operation == OP_REM_BACK)  ? list_count - 1 : pos - 1;
            if (list_count == 0) begin
               rsp.status = ST_EMPTY;
            end else if (slot < 0 || slot >= list_count) begin
               rsp.status = ST_BADPOS;
            end else begin
               for (int i = slot; i + 1 < list_count; i++) begin
                  list_keys[i]     = list_keys[i+1];
                  list_payloads[i] = list_payloads[i+1];
               end
               list_count--;
            end
         end
         OP_LOOKUP: begin
            if (list_count == 0) begin
               rsp.status = ST_EMPTY;
            end else begin
               rsp.status = ST_NOKEY;
               // last match wins
               for (int i = 0; i < list_count; i++) begin
                  if (list_keys[i] == op.key) begin
                     rsp.status        = ST_OK;
                     rsp.found_payload = list_payloads[i];
                  end
               end
            end
         end
         default: ;   // unused code: no change, ok status
      endcase
      rsp.entry_count = list_count[COUNT_W-1:0];
      return rsp;
   endfunction

   task automatic add_op(input logic [OP_W-1:0] operation, input int pos,
                         input logic signed [KEY_W-1:0] key,
                         input logic [PAYLOAD_W-1:0] payload);
      list_op_type op;
      op.operation    = operation;
      op.position     = pos[POS_W-1:0];
      op.key          = key;
      op.payload      = payload;
      op.wait_drained = gen_hold;
      op.calm         = gen_calm;
      gen_hold        = 1'b0;
      queued_ops.push_back(op);
      case (operation)
         OP_INS_FRONT, OP_INS_BACK: if (gen_count < LIST_DEPTH) gen_count++;
         OP_INS_AT:
            if (gen_count < LIST_DEPTH && pos <= gen_count) gen_count++;
         OP_REM_FRONT, OP_REM_BACK: if (gen_count > 0) gen_count--;
         OP_REM_AT:
            if (gen_count > 0 && pos >= 1 && pos <= gen_count) gen_count--;
         default: ;
      endcase
   endtask

   // Mostly hits on a small key set, sometimes any 32-bit key
   function automatic logic signed [KEY_W-1:0] pick_key();
      if ($urandom_range(0, 9) < 7) return key_pool[$urandom_range(0, 7)];
      return $urandom;
   endfunction

   // One random op; insert_pct biases inserts against removes so the list
   // wanders between empty and full.
   task automatic add_random_op(input int insert_pct);
      int                roll;
      int                pos;
      logic [OP_W-1:0]   operation;
      roll = $urandom_range(0, 99);
      if (roll < 5) begin
         // noise: any code, any position
         add_op(OP_W'($urandom_range(0, 7)), $urandom_range(0, 31), $urandom, $urandom);
      end else begin
         if (roll >= 75) begin
            operation = OP_LOOKUP;
         end else if ($urandom_range(0, 99) < insert_pct) begin
            case ($urandom_range(0, 2))
               0:       operation = OP_INS_FRONT;
               1:       operation = OP_INS_BACK;
               default: operation = OP_INS_AT;
            endcase
         end else begin
            case ($urandom_range(0, 2))
               0:       operation = OP_REM_FRONT;
               1:       operation = OP_REM_BACK;
               default: operation = OP_REM_AT;
            endcase
         end
         if (operation == OP_INS_AT)
            pos = $urandom_range(0, gen_count);
         else
            pos = (gen_count == 0) ? 0 : $urandom_range(1, gen_count);
         if ($urandom_range(0, 9) == 0) pos = $urandom_range(0, 31);
         add_op(operation, pos, pick_key(), $urandom);
      end
   endtask

   // Driver: presents queued ops, predicts each one as it is accepted, and
   // idles in short bursts. req_valid gets at most one NBA per edge.
   list_op_type cur_op;
   int          idle_left = 0;
   bit          req_taken;
   bit          rsp_taken;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         idle_left = 0;
      end else begin
         req_taken = req_valid && req_ready;
         rsp_taken = rsp_valid && rsp_ready;
         if (req_taken) begin
            predicted_rsps.push_back(apply_list_op(cur_op));
            ops_sent <= ops_sent + 1;
            if (!cur_op.calm && $urandom_range(0, 3) == 0)
               idle_left = $urandom_range(1, 5);
         end
         if (req_valid && !req_taken) begin
            // held transaction stays up, payload untouched
         end else if (idle_left > 0) begin
            idle_left--;
            req_valid <= 1'b0;
         end else if (queued_ops.size() != 0 &&
                      !(queued_ops[0].wait_drained &&
                        (ops_sent + int'(req_taken) != rsps_seen + int'(rsp_taken)))) begin
            cur_op = queued_ops.pop_front();
            req_valid     <= 1'b1;
            req_operation <= cur_op.operation;
            req_position  <= cur_op.position;
            req_key       <= cur_op.key;
            req_payload   <= cur_op.payload;
            calm_phase    <= cur_op.calm;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Monitor: checks each accepted response against the oldest prediction
   // and throttles rsp_ready in bursts.
   list_rsp_type want;
   int           stall_left = 0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            rsps_seen <= rsps_seen + 1;
            if (predicted_rsps.size() == 0) begin
               $error("response with no transaction outstanding");
               error_count++;
            end else begin
               want = predicted_rsps.pop_front();
               if (rsp_status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_status);
                  error_count++;
               end
               if (rsp_found_payload !== want.found_payload) begin
                  $error("found_payload: expected %h, got %h",
                         want.found_payload, rsp_found_payload);
                  error_count++;
               end
               if (rsp_entry_count !== want.entry_count) begin
                  $error("entry_count: expected %0d, got %0d",
                         want.entry_count, rsp_entry_count);
                  error_count++;
               end
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if (!calm_phase && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 4);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Stimulus, reset and end of run
   int ops_made;
   int seg_len;
   int insert_pct;

   initial begin
      key_pool[0] = 32'sh8000_0000;
      key_pool[1] = 32'sh7fff_ffff;
      key_pool[2] = -32'sd1;
      key_pool[3] = 32'sd0;
      for (int i = 4; i < 8; i++) key_pool[i] = $urandom;

      // Lookup, removes, the unused code and an insert past count on an empty list
      add_op(OP_LOOKUP,    0, 32'sd5, 32'h0);
      add_op(OP_REM_FRONT, 0, 32'sd0, 32'h0);
      add_op(OP_REM_BACK,  0, 32'sd0, 32'h0);
      add_op(OP_REM_AT,    1, 32'sd0, 32'h0);
      add_op(OP_UNUSED,    0, 32'sd0, 32'h0);
      add_op(OP_INS_AT,    1, 32'sd9, 32'h1111_1111);   // past count
      // Build a short list, extremes of key and payload, a duplicate key
      add_op(OP_INS_AT,    0, 32'sd5, 32'haaaa_0001);
      add_op(OP_INS_FRONT, 0, 32'sh8000_0000, 32'h0);
      add_op(OP_INS_BACK,  0, 32'sh7fff_ffff, 32'hffff_ffff);
      add_op(OP_INS_AT,    3, 32'sd5, 32'hbbbb_0002);   // at count: append
      add_op(OP_INS_AT,    2, -32'sd1, 32'h1234_5678);  // middle
      add_op(OP_LOOKUP,    0, 32'sd5, 32'h0);           // last match wins
      add_op(OP_LOOKUP,    0, 32'sh8000_0000, 32'h0);
      add_op(OP_LOOKUP,    0, 32'sd0, 32'h0);           // miss
      // Removes: zero index, index past count, then the good ones
      add_op(OP_REM_AT,    0, 32'sd0, 32'h0);
      add_op(OP_REM_AT,    6, 32'sd0, 32'h0);
      add_op(OP_REM_AT,    5, 32'sd0, 32'h0);
      add_op(OP_REM_AT,    2, 32'sd0, 32'h0);
      add_op(OP_REM_FRONT, 0, 32'sd0, 32'h0);
      add_op(OP_REM_BACK,  0, 32'sd0, 32'h0);
      add_op(OP_UNUSED,   31, 32'sh7fff_ffff, 32'hffff_ffff);
      add_op(OP_INS_AT,   31, 32'sd1, 32'h0);
      gen_hold = 1'b1;                                  // drain first
      add_op(OP_LOOKUP,    0, 32'sd5, 32'h0);

      // Fill past full, then the top position on a full list
      for (int i = 0; i < 18; i++) begin
         case ($urandom_range(0, 2))
            0:       add_op(OP_INS_FRONT, 0, pick_key(), $urandom);
            1:       add_op(OP_INS_BACK,  0, pick_key(), $urandom);
            default: add_op(OP_INS_AT, $urandom_range(0, gen_count), pick_key(), $urandom);
         endcase
      end
      add_op(OP_INS_AT, 16, pick_key(), $urandom);
      add_op(OP_LOOKUP,  0, pick_key(), 32'h0);
      add_op(OP_REM_AT, 16, 32'sd0, 32'h0);

      // Random segments drifting toward full, toward empty, or balanced
      ops_made = 0;
      while (ops_made < RANDOM_OPS) begin
         case ($urandom_range(0, 2))
            0:       insert_pct = 85;
            1:       insert_pct = 15;
            default: insert_pct = 50;
         endcase
         if ($urandom_range(0, 3) == 0) gen_hold = 1'b1;
         seg_len = $urandom_range(15, 40);
         for (int i = 0; i < seg_len && ops_made < RANDOM_OPS; i++) begin
            gen_calm = (ops_made >= RANDOM_OPS - CALM_TAIL);
            add_random_op(insert_pct);
            ops_made++;
         end
      end

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Sample away from the active edge so the driver/monitor order is moot
      do @(negedge clock);
      while (queued_ops.size() != 0 || req_valid || ops_sent != rsps_seen);
      repeat (LIST_DEPTH + 8) @(posedge clock);

      if (predicted_rsps.size() != 0) begin
         $error("%0d responses never arrived", predicted_rsps.size());
         error_count++;
      end
      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run (lookups with full stalls)
   initial begin
      #2ms;
      $display("TB_ERROR");
      $finish;
   end

endmodule
